### design/ees_pkg.sv
// ----------------------------------------------------------------------------
// ees_pkg: shared constants for the equivalent elastic strain pipeline
// Fixed-point formats, root width and the 1/(3*sqrt2) scale constant.
// ----------------------------------------------------------------------------
package ees_pkg;

  localparam int FIELD_W        = 32;
  localparam int IN_FRAC_DEFAULT  = 28;
  localparam int OUT_FRAC_DEFAULT = 24;
  localparam int WORK_FRAC_BITS = 30;
  localparam int Q_W            = 128;
  localparam int ROOT_W         = 64;
  localparam int SUM_W          = 66;
  localparam int C_W            = 64;
  localparam int SCALE_W        = 30;
  localparam logic [SCALE_W-1:0] INV_3SQRT2_Q32 = 30'd1012333500;

endpackage
// ----------------------------------------------------------------------------

### design/equivalent_elastic_strain.sv
// Throughput: one request per cycle while stall_i is low; the 64-stage
// square-root chain is fully unrolled, one root bit per stage, so nothing
// is shared.
// Bubbles collapse: a stage loads whenever it or the stage after it is free.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; payload
// registers are not reset.
// ----------------------------------------------------------------------------
// equivalent_elastic_strain: von Mises equivalent Green-Lagrange strain
// Forms C = F^T F, Q = sum of squared differences plus 6x shear squares,
// floor(sqrt(Q)) and scales by 1/(3*sqrt2), saturating to 32 bits.
// ----------------------------------------------------------------------------
module equivalent_elastic_strain import ees_pkg::*; #(
  parameter int IN_FRAC_BITS  = IN_FRAC_DEFAULT,
  parameter int OUT_FRAC_BITS = OUT_FRAC_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] f_xx_i,
  input  logic signed [31:0] f_xy_i,
  input  logic signed [31:0] f_xz_i,
  input  logic signed [31:0] f_yx_i,
  input  logic signed [31:0] f_yy_i,
  input  logic signed [31:0] f_yz_i,
  input  logic signed [31:0] f_zx_i,
  input  logic signed [31:0] f_zy_i,
  input  logic signed [31:0] f_zz_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [31:0]        equivalent_strain_o,
  output logic               saturated_o
);

  localparam int C_SHIFT  = 2 * IN_FRAC_BITS - WORK_FRAC_BITS;
  localparam int OUT_SH   = 2 * WORK_FRAC_BITS + 2 - OUT_FRAC_BITS;
  localparam int SQ_FIRST = 8;
  localparam int NS       = SQ_FIRST + ROOT_W + 1;
  localparam int FULL_W   = ROOT_W + 32;

  // pair (i,j) of each C entry: xx yy zz xy yz zx
  localparam int PI [6] = '{0, 1, 2, 0, 1, 2};
  localparam int PJ [6] = '{0, 1, 2, 1, 2, 0};

  logic [NS:1]   vld_q;
  logic [NS+1:1] ld;

  assign ld[NS+1] = !stall_i;
  for (genvar s = 1; s <= NS; s++) begin : g_ld
    assign ld[s] = !vld_q[s] || ld[s+1];
  end
  assign stall_o = !ld[1];
  assign valid_o = vld_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[1]) begin
        vld_q[1] <= valid_i;
      end
      for (int s = 2; s <= NS; s++) begin
        if (ld[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // stage 1: eighteen products
  logic signed [31:0] fa [9];
  assign fa[0] = f_xx_i; assign fa[1] = f_xy_i; assign fa[2] = f_xz_i;
  assign fa[3] = f_yx_i; assign fa[4] = f_yy_i; assign fa[5] = f_yz_i;
  assign fa[6] = f_zx_i; assign fa[7] = f_zy_i; assign fa[8] = f_zz_i;

  logic signed [63:0] prod_q [18];
  for (genvar c = 0; c < 6; c++) begin : g_prod
    for (genvar k = 0; k < 3; k++) begin : g_k
      always_ff @(posedge clk_i) begin
        if (ld[1]) prod_q[c*3+k] <= fa[k*3+PI[c]] * fa[k*3+PJ[c]];
      end
    end
  end

  // stage 2: C entries, one floor of the exact sum
  logic signed [C_W-1:0] c_q [6];
  for (genvar c = 0; c < 6; c++) begin : g_c
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] shf;
    assign sum = SUM_W'(prod_q[c*3]) + SUM_W'(prod_q[c*3+1]) + SUM_W'(prod_q[c*3+2]);
    assign shf = sum >>> C_SHIFT;
    always_ff @(posedge clk_i) begin
      if (ld[2]) c_q[c] <= shf[C_W-1:0];
    end
  end

  // stage 3: magnitudes of normal differences and shear terms
  logic [63:0] mag_q [6];
  for (genvar d = 0; d < 3; d++) begin : g_dmag
    logic signed [C_W:0] df;
    logic signed [C_W:0] ad;
    assign df = {c_q[d][C_W-1], c_q[d]} - {c_q[(d+1)%3][C_W-1], c_q[(d+1)%3]};
    assign ad = df[C_W] ? -df : df;
    always_ff @(posedge clk_i) begin
      if (ld[3]) mag_q[d] <= ad[63:0];
    end
  end
  for (genvar d = 3; d < 6; d++) begin : g_omag
    logic signed [C_W-1:0] ao;
    assign ao = c_q[d][C_W-1] ? -c_q[d] : c_q[d];
    always_ff @(posedge clk_i) begin
      if (ld[3]) mag_q[d] <= ao;
    end
  end

  // stage 4: 32x32 partial products of each square
  logic [63:0] pp_hh_q [6];
  logic [63:0] pp_hl_q [6];
  logic [63:0] pp_ll_q [6];
  for (genvar d = 0; d < 6; d++) begin : g_pp
    always_ff @(posedge clk_i) begin
      if (ld[4]) begin
        pp_hh_q[d] <= mag_q[d][63:32] * mag_q[d][63:32];
        pp_hl_q[d] <= mag_q[d][63:32] * mag_q[d][31:0];
        pp_ll_q[d] <= mag_q[d][31:0] * mag_q[d][31:0];
      end
    end
  end

  // stage 5: assemble squares
  logic [Q_W-1:0] sq_q [6];
  for (genvar d = 0; d < 6; d++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (ld[5]) begin
        sq_q[d] <= {pp_hh_q[d], 64'b0} + ({64'b0, pp_hl_q[d]} << 33)
                 + {64'b0, pp_ll_q[d]};
      end
    end
  end

  // stage 6: normal and shear sums
  logic [Q_W-1:0] dsum_q;
  logic [Q_W-1:0] osum_q;
  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      dsum_q <= sq_q[0] + sq_q[1] + sq_q[2];
      osum_q <= sq_q[3] + sq_q[4] + sq_q[5];
    end
  end

  // stage 7: Q = normal sum + 6 * shear sum
  logic [Q_W-1:0] q_q;
  always_ff @(posedge clk_i) begin
    if (ld[7]) q_q <= dsum_q + (osum_q << 2) + (osum_q << 1);
  end

  // stages 8..71: restoring square root, one bit per stage, rem = Q - root^2
  logic [Q_W-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - i;
    logic [Q_W-1:0]    cur_rem;
    logic [ROOT_W-1:0] cur_root;
    logic [Q_W-1:0]    trial;
    if (i == 0) begin : g_first
      assign cur_rem  = q_q;
      assign cur_root = '0;
    end else begin : g_next
      assign cur_rem  = rem_q[i-1];
      assign cur_root = root_q[i-1];
    end
    assign trial = ({64'b0, cur_root} << (B + 1)) | ({{(Q_W-1){1'b0}}, 1'b1} << (2 * B));
    always_ff @(posedge clk_i) begin
      if (ld[SQ_FIRST+i]) begin
        if (cur_rem >= trial) begin
          rem_q[i]  <= cur_rem - trial;
          root_q[i] <= cur_root | (ROOT_W'(1) << B);
        end else begin
          rem_q[i]  <= cur_rem;
          root_q[i] <= cur_root;
        end
      end
    end
  end

  // stage 72: scale partial products
  logic [63:0] sc_hi_q;
  logic [63:0] sc_lo_q;
  always_ff @(posedge clk_i) begin
    if (ld[NS-1]) begin
      sc_hi_q <= root_q[ROOT_W-1][63:32] * {2'b0, INV_3SQRT2_Q32};
      sc_lo_q <= root_q[ROOT_W-1][31:0]  * {2'b0, INV_3SQRT2_Q32};
    end
  end

  // stage 73: combine, shift, saturate
  logic [FULL_W-1:0] full;
  logic [FULL_W-1:0] shifted;
  assign full    = {sc_hi_q, 32'b0} + {32'b0, sc_lo_q};
  assign shifted = full >> OUT_SH;
  always_ff @(posedge clk_i) begin
    if (ld[NS]) begin
      if (shifted[FULL_W-1:32] != '0) begin
        equivalent_strain_o <= '1;
        saturated_o         <= 1'b1;
      end else begin
        equivalent_strain_o <= shifted[31:0];
        saturated_o         <= 1'b0;
      end
    end
  end

  // input only blocks when every stage holds a request behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i && (&vld_q)))
    else $error("input stalled with a free stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturated_o) |-> (equivalent_strain_o == '1))
    else $error("saturated result not at maximum");

  // floor root leaves remainder of at most 2*root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-2] |-> (rem_q[ROOT_W-1] <= ({64'b0, root_q[ROOT_W-1]} << 1)))
    else $error("square root remainder too large");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && !ld[2]) |=> vld_q[1])
    else $error("request dropped in first stage");

endmodule
// ----------------------------------------------------------------------------

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for equivalent_elastic_strain
// Streams deformation gradients through the pipeline under random valid and
// stall gaps. Each accepted request is predicted in wide integer arithmetic
// and compared in order with the results that come out.
// ----------------------------------------------------------------------------
module tb import ees_pkg::*; ();

  localparam int LATENCY = 72;
  localparam int NUM_RANDOM = 480;

  typedef logic signed [31:0] entry_t;
  typedef entry_t grad_t [9];

  typedef struct packed {
    logic [31:0] strain;
    logic        sat;
  } strain_t;

  class strain_scoreboard;
    strain_t pending_q[$];
    int      mismatches = 0;
    int      checked = 0;
    int      saturated_seen = 0;

    // entry (i,j) of F^T F with 30 fraction bits, one floor
    static function logic signed [65:0] right_cauchy(grad_t f, int i, int j);
      logic signed [65:0] acc;
      acc = '0;
      for (int k = 0; k < 3; k++)
        acc += 66'(longint'(f[k*3+i]) * longint'(f[k*3+j]));
      return acc >>> (2 * IN_FRAC_DEFAULT - WORK_FRAC_BITS);
    endfunction

    static function logic [127:0] square(logic signed [65:0] x);
      logic [65:0] m;
      m = x[65] ? -x : x;
      return {62'b0, m} * {62'b0, m};
    endfunction

    static function strain_t von_mises(grad_t f);
      logic signed [65:0] cxx, cyy, czz, cxy, cyz, czx;
      logic [127:0] q, shear;
      logic [63:0]  root, cand;
      logic [127:0] scaled;
      strain_t      res;
      cxx = right_cauchy(f, 0, 0);
      cyy = right_cauchy(f, 1, 1);
      czz = right_cauchy(f, 2, 2);
      cxy = right_cauchy(f, 0, 1);
      cyz = right_cauchy(f, 1, 2);
      czx = right_cauchy(f, 2, 0);
      shear = square(cxy) + square(cyz) + square(czx);
      q = square(cxx - cyy) + square(cyy - czz) + square(czz - cxx) + shear * 6;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if ({64'b0, cand} * {64'b0, cand} <= q) root = cand;
      end
      scaled = ({64'b0, root} * 128'd1012333500) >> (62 - OUT_FRAC_DEFAULT);
      if (scaled[127:32] != '0) begin
        res.strain = '1;
        res.sat = 1'b1;
      end else begin
        res.strain = scaled[31:0];
        res.sat = 1'b0;
      end
      return res;
    endfunction

    function void note_request(grad_t f);
      pending_q.push_back(von_mises(f));
    endfunction

    function void check_result(logic [31:0] strain, logic sat);
      strain_t exp_r;
      checked++;
      if (sat) saturated_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: strain=%h sat=%b", strain, sat);
        return;
      end
      exp_r = pending_q.pop_front();
      if (strain !== exp_r.strain || sat !== exp_r.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: strain exp %h got %h, sat exp %b got %b",
                   checked, exp_r.strain, strain, exp_r.sat, sat);
      end
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   valid_i = 1'b0;
  logic   stall_i = 1'b0;
  logic   stall_o, valid_o, saturated_o;
  logic [31:0] equivalent_strain_o;
  entry_t f_in [9] = '{default: '0};

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int sent = 0;

  strain_scoreboard sb = new();

  always #2 clk_i = ~clk_i;

  equivalent_elastic_strain uut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .f_xx_i(f_in[0]), .f_xy_i(f_in[1]), .f_xz_i(f_in[2]),
    .f_yx_i(f_in[3]), .f_yy_i(f_in[4]), .f_yz_i(f_in[5]),
    .f_zx_i(f_in[6]), .f_zy_i(f_in[7]), .f_zz_i(f_in[8]),
    .valid_o, .stall_i, .equivalent_strain_o, .saturated_o
  );

  // result side: check, then pick next stall (long hold-off when asked)
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) sb.check_result(equivalent_strain_o, saturated_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_request(grad_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    for (int i = 0; i < 9; i++) f_in[i] <= f[i];
    do @(posedge clk_i); while (stall_o);
    sb.note_request(f);
    sent++;
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic grad_t identity_plus(int unsigned span);
    grad_t f;
    for (int i = 0; i < 9; i++) begin
      f[i] = entry_t'($urandom_range(2 * span)) - entry_t'(span);
      if (i % 4 == 0) f[i] += entry_t'(1 << IN_FRAC_DEFAULT);
    end
    return f;
  endfunction

  function automatic grad_t random_grad();
    grad_t f;
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind < 5) return identity_plus(1 << $urandom_range(27, 4));
    for (int i = 0; i < 9; i++) begin
      f[i] = $urandom();
      if (kind < 8) f[i] = f[i] >>> $urandom_range(6, 1);
    end
    return f;
  endfunction

  task automatic directed();
    grad_t f;
    entry_t one;
    one = entry_t'(1 << IN_FRAC_DEFAULT);
    f = '{one, 0, 0, 0, one, 0, 0, 0, one};                send_request(f);
    f = '{default: '0};                                    send_request(f);
    f = '{default: 32'h7fffffff};                          send_request(f);
    f = '{default: 32'h80000000};                          send_request(f);
    f = '{default: 32'h55555555};                          send_request(f);
    f = '{default: 32'haaaaaaaa};                          send_request(f);
    f = '{default: -32'sd1};                               send_request(f);
    f = '{-one, 0, 0, 0, -one, 0, 0, 0, one};              send_request(f);
    f = '{one * 2, 0, 0, 0, one, 0, 0, 0, one};            send_request(f);
    f = '{one, one >>> 4, 0, 0, one, 0, 0, 0, one};        send_request(f);
    f = '{one, 0, 0, 0, one, -(one >>> 3), 0, 0, one};     send_request(f);
    f = '{one, 0, 0, 0, one, 0, one >>> 2, 0, one};        send_request(f);
    for (int i = 0; i < 9; i++) begin
      f = '{default: '0};
      f[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
      send_request(f);
    end
    f = '{32'h7fffffff, 0, 0, 0, 32'h80000000, 0, 0, 0, 0}; send_request(f);
    // large stretch along x, result still well below the saturation threshold
    f = '{one * 4, 0, 0, 0, one >>> 1, 0, 0, 0, one >>> 1}; send_request(f);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 57 : 0;
      recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 12 : 0;
      if (ph == 0) directed();
      for (int n = 0; n < NUM_RANDOM / 3; n++) begin
        if (ph == 0 && n == 40) hold_req = 1'b1;
        if (ph == 1 && n == 60) begin
          // sender waits for the pipe to empty completely
          drain();
        end
        send_request(random_grad());
      end
    end
    drain();
    $display("sent %0d requests, checked %0d results (%0d saturated)",
             sent, sb.checked, sb.saturated_seen);
    $display("covered identity, extremes, shear cases, backpressure and pipe drain");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(4 * 400000);
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end
endmodule

### files.f
design/ees_pkg.sv
design/equivalent_elastic_strain.sv
verif/tb.sv
